### sv/occupancy_grid_ray_update_defines.svh
// Assertion macros used by the checker of the occupancy grid ray update block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef OCCUPANCY_GRID_RAY_UPDATE_DEFINES_SVH
`define OCCUPANCY_GRID_RAY_UPDATE_DEFINES_SVH

// The consequent must hold at the same clock edge as the antecedent.
`define OGRU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold at the clock edge after the antecedent.
`define OGRU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ogru_pkg.sv
// Package of the occupancy grid ray update block: field widths, codes and the
// configuration, command and status structs. Depends on nothing.
package ogru_pkg;

  localparam int COORD_W    = 11;
  localparam int VALUE_W    = 12;
  localparam int COUNT_W    = 9;
  localparam int DIM_REG_W  = 9;
  localparam int STEP_W     = 11;
  localparam int FLOOR_W    = 12;
  localparam int CEIL_W     = 11;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam logic KIND_RAY    = 1'b0;
  localparam logic KIND_READ   = 1'b1;
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_SKIP = 1'b1;

  typedef struct packed {
    logic        [DIM_REG_W-1:0] grid_width;
    logic        [DIM_REG_W-1:0] grid_height;
    logic        [STEP_W-1:0]    occupied_step;
    logic        [STEP_W-1:0]    free_step;
    logic signed [FLOOR_W-1:0]   floor_value;
    logic        [CEIL_W-1:0]    ceiling_value;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic rd_end;
    logic walk;
    logic rd_take;
    logic skip;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic kind;
    logic skip;
    logic at_end;
  } sts_t;

endpackage

### sv/ogru_req_if.sv
// Input channel of the occupancy grid ray update block: one ray or read item.
// Depends on ogru_pkg for the field widths.
interface ogru_req_if import ogru_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;

  modport source (output valid, kind, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, kind, start_x, start_y, end_x, end_y, output ready);
endinterface

### sv/ogru_rsp_if.sv
// Output channel of the occupancy grid ray update block: one result item.
// Depends on ogru_pkg for the field widths.
interface ogru_rsp_if import ogru_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      status;
  logic signed [VALUE_W-1:0] cell_value;
  logic        [COUNT_W-1:0] cells_touched;

  modport source (output valid, status, cell_value, cells_touched, input ready);
  modport sink   (input valid, status, cell_value, cells_touched, output ready);
endinterface

### sv/occupancy_grid_ray_update.sv
// Top level of the occupancy grid ray update block: APB-style registers,
// controller and datapath. Depends on ogru_pkg, ogru_req_if, ogru_rsp_if,
// ogru_regs, ogru_ctrl and ogru_dp.
//
// The block keeps a GRID_DIM_MAX by GRID_DIM_MAX grid of signed log-odds
// values (CELL_BITS wide, eight fraction bits) in one on-chip memory with a
// write port and a registered read port. After reset a clearing pass writes
// zero to every entry, one entry a cycle; req.ready stays low until it is
// done, while register writes are taken as usual. A ray item walks the line
// from its start cell to its end cell and updates one cell per cycle,
// reading the next cell while the previous one is written back. After the
// check state a ray runs the walk and a drain state, a read item reads its
// end cell, and a skipped item goes straight on to the hand-off; a new item
// is taken only once the last result has gone to the output register. The
// one-cell-per-cycle rate is set by the single read and single write port
// of the grid memory. The result goes to an output register, so the next
// item is accepted while a finished result still waits on rsp. Registers
// sit at byte addresses 4 * index: grid width, grid height, occupied step,
// free step, floor value and ceiling value. They are meant to be written
// only while the block is idle. pready is always high.
module occupancy_grid_ray_update import ogru_pkg::*; #(
  parameter int GRID_DIM_MAX = 256,
  parameter int CELL_BITS    = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  ogru_req_if.sink              req,
  ogru_rsp_if.source            rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // Every access completes in its access cycle.
  assign pready = 1'b1;

  ogru_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // The controller sequences clearing, checking, the line walk or the read
  // and the hand-off of each result to the output register.
  ogru_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .sts       (sts),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  // The datapath holds the grid memory, the line stepper and the results.
  ogru_dp #(
    .GRID_DIM_MAX (GRID_DIM_MAX),
    .CELL_BITS    (CELL_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .sts         (sts),
    .kind        (req.kind),
    .start_x     (req.start_x),
    .start_y     (req.start_y),
    .end_x       (req.end_x),
    .end_y       (req.end_y),
    .out_status  (rsp.status),
    .out_value   (rsp.cell_value),
    .out_touched (rsp.cells_touched)
  );

endmodule

### sv/ogru_regs.sv
// Configuration register file behind the APB-style port.
// Depends on ogru_pkg for cfg_t and the port widths.
module ogru_regs import ogru_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output cfg_t                  cfg
);

  typedef enum logic [2:0] {
    REG_GRID_WIDTH    = 3'd0,
    REG_GRID_HEIGHT   = 3'd1,
    REG_OCCUPIED_STEP = 3'd2,
    REG_FREE_STEP     = 3'd3,
    REG_FLOOR_VALUE   = 3'd4,
    REG_CEILING_VALUE = 3'd5
  } reg_idx_t;

  localparam logic        [DIM_REG_W-1:0] RST_GRID_WIDTH    = DIM_REG_W'(256);
  localparam logic        [DIM_REG_W-1:0] RST_GRID_HEIGHT   = DIM_REG_W'(256);
  localparam logic        [STEP_W-1:0]    RST_OCCUPIED_STEP = STEP_W'(218);
  localparam logic        [STEP_W-1:0]    RST_FREE_STEP     = STEP_W'(102);
  localparam logic signed [FLOOR_W-1:0]   RST_FLOOR_VALUE   = -FLOOR_W'(1024);
  localparam logic        [CEIL_W-1:0]    RST_CEILING_VALUE = CEIL_W'(1024);

  reg_idx_t idx;
  logic     wr_en;

  assign idx   = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_width    <= RST_GRID_WIDTH;
      cfg.grid_height   <= RST_GRID_HEIGHT;
      cfg.occupied_step <= RST_OCCUPIED_STEP;
      cfg.free_step     <= RST_FREE_STEP;
      cfg.floor_value   <= RST_FLOOR_VALUE;
      cfg.ceiling_value <= RST_CEILING_VALUE;
    end else if (wr_en) begin
      unique case (idx)
        REG_GRID_WIDTH:    cfg.grid_width    <= pwdata[DIM_REG_W-1:0];
        REG_GRID_HEIGHT:   cfg.grid_height   <= pwdata[DIM_REG_W-1:0];
        REG_OCCUPIED_STEP: cfg.occupied_step <= pwdata[STEP_W-1:0];
        REG_FREE_STEP:     cfg.free_step     <= pwdata[STEP_W-1:0];
        REG_FLOOR_VALUE:   cfg.floor_value   <= pwdata[FLOOR_W-1:0];
        REG_CEILING_VALUE: cfg.ceiling_value <= pwdata[CEIL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GRID_WIDTH:    prdata = APB_DATA_W'(cfg.grid_width);
      REG_GRID_HEIGHT:   prdata = APB_DATA_W'(cfg.grid_height);
      REG_OCCUPIED_STEP: prdata = APB_DATA_W'(cfg.occupied_step);
      REG_FREE_STEP:     prdata = APB_DATA_W'(cfg.free_step);
      REG_FLOOR_VALUE:   prdata = APB_DATA_W'(cfg.floor_value);
      REG_CEILING_VALUE: prdata = APB_DATA_W'(cfg.ceiling_value);
      default:           prdata = '0;
    endcase
  end

endmodule

### sv/ogru_ctrl.sv
// Controller state machine of the occupancy grid ray update block.
// Depends on ogru_pkg for the command and status structs and the item codes.
module ogru_ctrl import ogru_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  sts_t sts,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_DRAIN,
    ST_READ,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.skip) begin
          cmd.skip   = 1'b1;
          state_next = ST_DONE;
        end else if (sts.kind == KIND_READ) begin
          cmd.rd_end = 1'b1;
          state_next = ST_READ;
        end else begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (sts.at_end) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_DONE;
      ST_READ: begin
        cmd.rd_take = 1'b1;
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### sv/ogru_dp.sv
// Datapath of the occupancy grid ray update block: grid memory, line stepper,
// read-modify-write stage and result registers. Depends on ogru_pkg.
module ogru_dp import ogru_pkg::*; #(
  parameter int GRID_DIM_MAX = 256,
  parameter int CELL_BITS    = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cfg_t                      cfg,
  input  cmd_t                      cmd,
  output sts_t                      sts,
  input  logic                      kind,
  input  logic signed [COORD_W-1:0] start_x,
  input  logic signed [COORD_W-1:0] start_y,
  input  logic signed [COORD_W-1:0] end_x,
  input  logic signed [COORD_W-1:0] end_y,
  output logic                      out_status,
  output logic signed [VALUE_W-1:0] out_value,
  output logic        [COUNT_W-1:0] out_touched
);

  localparam int DEPTH  = GRID_DIM_MAX * GRID_DIM_MAX;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ERR_W  = COORD_W + 3;
  localparam int CALC_W = ((CELL_BITS > VALUE_W) ? CELL_BITS : VALUE_W) + 2;
  localparam logic signed [CALC_W-1:0] CELL_HI =
    {{(CALC_W-CELL_BITS+1){1'b0}}, {(CELL_BITS-1){1'b1}}};
  localparam logic signed [CALC_W-1:0] CELL_LO = ~CELL_HI;

  logic [CELL_BITS-1:0] mem [DEPTH];
  logic [CELL_BITS-1:0] rdata;

  logic                      kind_r;
  logic signed [COORD_W-1:0] cx, cy, x1, y1;
  logic signed [ERR_W-1:0]   dx, dy, err;
  logic                      sx, sy;

  logic              pend_valid;
  logic              pend_end;
  logic [ADDR_W-1:0] pend_addr;
  logic [ADDR_W-1:0] clr_cnt;

  logic                      res_status;
  logic signed [VALUE_W-1:0] res_value;
  logic        [COUNT_W-1:0] touched;

  logic [COORD_W-1:0] eff_w, eff_h;
  logic               start_in, end_in, at_end;
  logic [ADDR_W-1:0]  cur_addr, end_addr;

  function automatic logic in_grid(input logic signed [COORD_W-1:0] x,
                                   input logic signed [COORD_W-1:0] y,
                                   input logic [COORD_W-1:0] w,
                                   input logic [COORD_W-1:0] h);
    return !x[COORD_W-1] && !y[COORD_W-1] && ($unsigned(x) < w) && ($unsigned(y) < h);
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic signed [COORD_W-1:0] x,
                                                input logic signed [COORD_W-1:0] y);
    logic [ADDR_W-1:0] xa;
    logic [ADDR_W-1:0] ya;
    xa = ADDR_W'($unsigned(x));
    ya = ADDR_W'($unsigned(y));
    return ADDR_W'(ya * ADDR_W'(GRID_DIM_MAX) + xa);
  endfunction

  // Grid size registers above the store's dimension saturate to it.
  assign eff_w = (COORD_W'(cfg.grid_width) > COORD_W'(GRID_DIM_MAX)) ?
                 COORD_W'(GRID_DIM_MAX) : COORD_W'(cfg.grid_width);
  assign eff_h = (COORD_W'(cfg.grid_height) > COORD_W'(GRID_DIM_MAX)) ?
                 COORD_W'(GRID_DIM_MAX) : COORD_W'(cfg.grid_height);

  assign start_in = in_grid(cx, cy, eff_w, eff_h);
  assign end_in   = in_grid(x1, y1, eff_w, eff_h);
  assign at_end   = (cx == x1) && (cy == y1);
  assign cur_addr = addr_of(cx, cy);
  assign end_addr = addr_of(x1, y1);

  assign sts.clear_last = (clr_cnt == ADDR_W'(DEPTH - 1));
  assign sts.kind       = kind_r;
  assign sts.skip       = (kind_r == KIND_READ) ? !end_in : (!start_in || !end_in);
  assign sts.at_end     = at_end;

  // Initial line terms from the incoming item.
  logic signed [COORD_W:0]  ddx, ddy, adx, ady;
  logic signed [ERR_W-1:0]  dx_load, dy_load;

  assign ddx     = {end_x[COORD_W-1], end_x} - {start_x[COORD_W-1], start_x};
  assign ddy     = {end_y[COORD_W-1], end_y} - {start_y[COORD_W-1], start_y};
  assign adx     = ddx[COORD_W] ? -ddx : ddx;
  assign ady     = ddy[COORD_W] ? -ddy : ddy;
  assign dx_load = ERR_W'(adx);
  assign dy_load = -ERR_W'(ady);

  // One Bresenham step.
  logic signed [ERR_W-1:0] e2;
  logic                    step_x, step_y;

  assign e2     = err <<< 1;
  assign step_x = (e2 >= dy);
  assign step_y = (e2 <= dx);

  // Update of the cell whose read data has just come back.
  logic signed [CALC_W-1:0] rd_ext, free_ext, occ_ext, floor_ext, ceil_ext;
  logic signed [CALC_W-1:0] dec, inc, upd, upd_sat;

  assign rd_ext    = {{(CALC_W-CELL_BITS){rdata[CELL_BITS-1]}}, rdata};
  assign free_ext  = CALC_W'(cfg.free_step);
  assign occ_ext   = CALC_W'(cfg.occupied_step);
  assign floor_ext = {{(CALC_W-FLOOR_W){cfg.floor_value[FLOOR_W-1]}}, cfg.floor_value};
  assign ceil_ext  = CALC_W'(cfg.ceiling_value);

  always_comb begin
    dec = rd_ext - free_ext;
    if (dec < floor_ext) dec = floor_ext;
    inc = rd_ext + occ_ext;
    if (inc > ceil_ext) inc = ceil_ext;
    upd = pend_end ? inc : dec;
    if (upd > CELL_HI) begin
      upd_sat = CELL_HI;
    end else if (upd < CELL_LO) begin
      upd_sat = CELL_LO;
    end else begin
      upd_sat = upd;
    end
  end

  // Memory ports: one write, one registered read.
  logic                 we, re;
  logic [ADDR_W-1:0]    waddr, raddr;
  logic [CELL_BITS-1:0] wdata;

  assign we    = cmd.clear || pend_valid;
  assign waddr = cmd.clear ? clr_cnt : pend_addr;
  assign wdata = cmd.clear ? '0 : upd_sat[CELL_BITS-1:0];
  assign re    = cmd.walk || cmd.rd_end;
  assign raddr = cmd.rd_end ? end_addr : cur_addr;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

  // Control state of the datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.clear) clr_cnt <= clr_cnt + ADDR_W'(1);
      pend_valid <= cmd.walk;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind;
      cx     <= start_x;
      cy     <= start_y;
      x1     <= end_x;
      y1     <= end_y;
      dx     <= dx_load;
      dy     <= dy_load;
      err    <= dx_load + dy_load;
      sx     <= (start_x < end_x);
      sy     <= (start_y < end_y);
    end else if (cmd.walk) begin
      pend_addr <= cur_addr;
      pend_end  <= at_end;
      if (!at_end) begin
        err <= err + (step_x ? dy : ERR_W'(0)) + (step_y ? dx : ERR_W'(0));
        if (step_x) cx <= sx ? cx + COORD_W'(1) : cx - COORD_W'(1);
        if (step_y) cy <= sy ? cy + COORD_W'(1) : cy - COORD_W'(1);
      end
    end

    if (cmd.load) begin
      res_status <= STATUS_DONE;
      res_value  <= '0;
      touched    <= '0;
    end else begin
      if (cmd.skip) res_status <= STATUS_SKIP;
      if (cmd.rd_take) res_value <= rd_ext[VALUE_W-1:0];
      if (pend_valid) begin
        touched <= touched + COUNT_W'(1);
        if (pend_end) res_value <= upd_sat[VALUE_W-1:0];
      end
    end

    if (cmd.out_load) begin
      out_status  <= res_status;
      out_value   <= res_value;
      out_touched <= touched;
    end
  end

endmodule

### sv/ogru_checker.sv
// Port-level checker of the occupancy grid ray update block and its bind.
// Depends on ogru_pkg and occupancy_grid_ray_update_defines.svh.
`include "occupancy_grid_ray_update_defines.svh"

module ogru_checker import ogru_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_ready,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic                      rsp_status,
  input logic signed [VALUE_W-1:0] rsp_cell_value,
  input logic        [COUNT_W-1:0] rsp_cells_touched
);

  // The grid is being cleared right after reset, so no item may be taken.
  `OGRU_ASSERT_SAME(a_clear_after_reset, $past(rst), !req_ready, "item taken during clear")

  // Items are worked one at a time: an accepted item blocks the next cycle.
  `OGRU_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready,
                    "second item taken right after an accept")

  // A skipped item leaves no value and no touched cells.
  `OGRU_ASSERT_SAME(a_skip_empty, rsp_valid && (rsp_status == STATUS_SKIP),
                    (rsp_cell_value == '0) && (rsp_cells_touched == '0),
                    "skipped item carries data")

  // A waiting result holds until it is taken.
  `OGRU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_status) && $stable(rsp_cell_value) &&
                    $stable(rsp_cells_touched), "result changed while stalled")

endmodule

bind occupancy_grid_ray_update ogru_checker u_ogru_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_cell_value    (rsp.cell_value),
  .rsp_cells_touched (rsp.cells_touched)
);

### dv/tb_occupancy_grid_ray_update.sv
// Self-checking testbench of the occupancy grid ray update block: rays and reads
// go in over the request channel and each result is checked against a predictor
// in this file. Depends on ogru_pkg, ogru_req_if, ogru_rsp_if and the block.
module tb_occupancy_grid_ray_update;
  import ogru_pkg::*;

  // The block is built at its default size. The predictor keeps a grid of the
  // same size and saturates stored values to the same cell width.
  localparam int GRID_DIM       = 256;
  localparam int CELL_W         = 12;
  localparam int CELL_MAX       = (1 << (CELL_W - 1)) - 1;
  localparam int CELL_MIN       = -(1 << (CELL_W - 1));
  // The clearing pass after reset keeps the request channel shut while it
  // writes every grid entry, so the watchdog limit lies well above that pass.
  localparam int WATCHDOG_LIMIT = 300000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 20;
  localparam int MAX_PRINTED    = 40;

  // Register indexes; each sits at byte address 4 * index.
  localparam int REG_GRID_WIDTH    = 0;
  localparam int REG_GRID_HEIGHT   = 1;
  localparam int REG_OCCUPIED_STEP = 2;
  localparam int REG_FREE_STEP     = 3;
  localparam int REG_FLOOR_VALUE   = 4;
  localparam int REG_CEILING_VALUE = 5;

  typedef struct {
    logic                      kind;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
  } ray_item_t;

  typedef struct {
    logic                      status;
    logic signed [VALUE_W-1:0] cell_value;
    logic        [COUNT_W-1:0] cells_touched;
  } grid_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  ogru_req_if req_ch ();
  ogru_rsp_if rsp_ch ();

  occupancy_grid_ray_update #(
    .GRID_DIM_MAX(GRID_DIM),
    .CELL_BITS   (CELL_W)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .req    (req_ch),
    .rsp    (rsp_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: its own copy of the grid and of the registers. The grid
  // is addressed as row * GRID_DIM + column whatever size is configured, so a
  // resize leaves the stored values in place, as in the block.
  int           grid_cells [GRID_DIM * GRID_DIM];
  cfg_t         grid_cfg;

  ray_item_t    pending_items [$];
  grid_result_t grid_results [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int results_seen   = 0;
  int stall_cycles   = 0;

  // A size register above the grid dimension behaves as the full dimension.
  function automatic int eff_dim(logic [DIM_REG_W-1:0] size_reg);
    return (int'(size_reg) > GRID_DIM) ? GRID_DIM : int'(size_reg);
  endfunction

  function automatic bit on_grid(int x, int y);
    return x >= 0 && y >= 0 && x < eff_dim(grid_cfg.grid_width) &&
           y < eff_dim(grid_cfg.grid_height);
  endfunction

  function automatic int cell_clip(int v);
    if (v > CELL_MAX) return CELL_MAX;
    if (v < CELL_MIN) return CELL_MIN;
    return v;
  endfunction

  // Applies one accepted item to the grid and returns the result it causes.
  // A ray walks the Bresenham line; every cell but the last is lowered by the
  // free step and held at the floor, then the end cell is raised by the
  // occupied step and held at the ceiling. Floor and ceiling are applied
  // only on their own side, so a floor above the ceiling is not reconciled.
  function automatic grid_result_t apply_item(ray_item_t it);
    grid_result_t r;
    int x0, y0, x1, y1, dx, dy, step_x, step_y, err, e2, cx, cy, v, touched;
    int unsigned a;
    x0 = it.start_x;
    y0 = it.start_y;
    x1 = it.end_x;
    y1 = it.end_y;
    r.status        = STATUS_DONE;
    r.cell_value    = '0;
    r.cells_touched = '0;
    if (it.kind == KIND_READ) begin
      if (on_grid(x1, y1)) begin
        r.cell_value = VALUE_W'(grid_cells[y1 * GRID_DIM + x1]);
      end else begin
        r.status = STATUS_SKIP;
      end
      return r;
    end
    if (!on_grid(x0, y0) || !on_grid(x1, y1)) begin
      r.status = STATUS_SKIP;
      return r;
    end
    dx      = (x1 >= x0) ? x1 - x0 : x0 - x1;
    dy      = -((y1 >= y0) ? y1 - y0 : y0 - y1);
    step_x  = (x0 < x1) ? 1 : -1;
    step_y  = (y0 < y1) ? 1 : -1;
    err     = dx + dy;
    cx      = x0;
    cy      = y0;
    touched = 0;
    while (!(cx == x1 && cy == y1)) begin
      e2 = 2 * err;
      a  = cy * GRID_DIM + cx;
      v  = grid_cells[a] - int'(grid_cfg.free_step);
      if (v < int'(grid_cfg.floor_value)) v = int'(grid_cfg.floor_value);
      grid_cells[a] = cell_clip(v);
      touched++;
      if (e2 >= dy) begin
        err += dy;
        cx  += step_x;
      end
      if (e2 <= dx) begin
        err += dx;
        cy  += step_y;
      end
    end
    a = y1 * GRID_DIM + x1;
    v = grid_cells[a] + int'(grid_cfg.occupied_step);
    if (v > int'(grid_cfg.ceiling_value)) v = int'(grid_cfg.ceiling_value);
    v = cell_clip(v);
    grid_cells[a] = v;
    touched++;
    r.cell_value    = VALUE_W'(v);
    r.cells_touched = COUNT_W'(touched);
    return r;
  endfunction

  // Mostly a coordinate inside the configured size, sometimes one right at
  // an edge or just past it, and now and then any 11-bit value.
  function automatic logic signed [COORD_W-1:0] pick_coord(int dim);
    logic signed [COORD_W-1:0] c;
    int                        sel;
    sel = $urandom_range(99);
    if (sel < 84) begin
      c = (dim > 0) ? COORD_W'($urandom_range(dim - 1)) : '0;
    end else if (sel < 94) begin
      case ($urandom_range(3))
        0: c = COORD_W'(-1);
        1: c = '0;
        2: c = COORD_W'(dim - 1);
        default: c = COORD_W'(dim);
      endcase
    end else begin
      c = COORD_W'($urandom);
    end
    return c;
  endfunction

  // Three in four items are rays over the configured grid, some are reads,
  // and one in ten is noise with every field drawn from its full range.
  function automatic ray_item_t random_item();
    ray_item_t it;
    int        sel, w, h;
    w   = eff_dim(grid_cfg.grid_width);
    h   = eff_dim(grid_cfg.grid_height);
    sel = $urandom_range(99);
    if (sel < 10) begin
      it.kind    = 1'($urandom_range(1));
      it.start_x = COORD_W'($urandom);
      it.start_y = COORD_W'($urandom);
      it.end_x   = COORD_W'($urandom);
      it.end_y   = COORD_W'($urandom);
    end else begin
      it.kind    = (sel < 25) ? KIND_READ : KIND_RAY;
      it.start_x = pick_coord(w);
      it.start_y = pick_coord(h);
      it.end_x   = pick_coord(w);
      it.end_y   = pick_coord(h);
    end
    return it;
  endfunction

  task automatic queue_item(logic kind, int sx, int sy, int ex, int ey);
    ray_item_t it;
    it.kind    = kind;
    it.start_x = COORD_W'(sx);
    it.start_y = COORD_W'(sy);
    it.end_x   = COORD_W'(ex);
    it.end_y   = COORD_W'(ey);
    pending_items.push_back(it);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("[%0t] result %0d, %s: got %0d, expected %0d",
               $time, results_seen, what, got, want);
    end
  endtask

  // One APB write: a setup cycle, then an access cycle. The register takes
  // the value at the edge that ends the access cycle, and the predictor's
  // copy is updated at that same edge.
  task automatic reg_write(int idx, logic [APB_DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * idx);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_GRID_WIDTH:    grid_cfg.grid_width    = value[DIM_REG_W-1:0];
      REG_GRID_HEIGHT:   grid_cfg.grid_height   = value[DIM_REG_W-1:0];
      REG_OCCUPIED_STEP: grid_cfg.occupied_step = value[STEP_W-1:0];
      REG_FREE_STEP:     grid_cfg.free_step     = value[STEP_W-1:0];
      REG_FLOOR_VALUE:   grid_cfg.floor_value   = value[FLOOR_W-1:0];
      REG_CEILING_VALUE: grid_cfg.ceiling_value = value[CEIL_W-1:0];
      default: ;
    endcase
  endtask

  // Waits until every queued item went in and every result came back. The
  // check runs on the falling edge, where the driver's and the monitor's
  // updates of the rising edge have all landed. A settling wait follows so
  // the block is surely back at rest before the registers change.
  task automatic wait_until_idle();
    do begin
      @(negedge clk);
    end while (pending_items.size() != 0 || req_ch.valid || grid_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One phase: a full register setting, an idling pattern and a batch of
  // random items, run until the block has drained.
  task automatic run_phase(int width, int height, int occ_step, int free_dec, int flr,
                           int ceil_v, int send_pct, int recv_pct, int n_items);
    reg_write(REG_GRID_WIDTH, width);
    reg_write(REG_GRID_HEIGHT, height);
    reg_write(REG_OCCUPIED_STEP, occ_step);
    reg_write(REG_FREE_STEP, free_dec);
    reg_write(REG_FLOOR_VALUE, flr);
    reg_write(REG_CEILING_VALUE, ceil_v);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n_items) pending_items.push_back(random_item());
    wait_until_idle();
  endtask

  // Driver: offers the next pending item whenever the channel is free, or
  // holds off at random. An item taken at this edge is run through the
  // predictor before anything else changes, so its expected result is queued
  // in item order.
  always @(posedge clk) begin : driver
    ray_item_t taken;
    ray_item_t next_item;
    if (rst) begin
      req_ch.valid   <= 1'b0;
      req_ch.kind    <= KIND_RAY;
      req_ch.start_x <= '0;
      req_ch.start_y <= '0;
      req_ch.end_x   <= '0;
      req_ch.end_y   <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        taken.kind    = req_ch.kind;
        taken.start_x = req_ch.start_x;
        taken.start_y = req_ch.start_y;
        taken.end_x   = req_ch.end_x;
        taken.end_y   = req_ch.end_y;
        grid_results.push_back(apply_item(taken));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = pending_items.pop_front();
          req_ch.valid   <= 1'b1;
          req_ch.kind    <= next_item.kind;
          req_ch.start_x <= next_item.start_x;
          req_ch.start_y <= next_item.start_y;
          req_ch.end_x   <= next_item.end_x;
          req_ch.end_y   <= next_item.end_y;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: each result taken is compared field by field with the oldest
  // expected result. The ready it offers stalls at random.
  always @(posedge clk) begin : monitor
    grid_result_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        if (grid_results.size() == 0) begin
          report_mismatch("result with no item waiting", int'(rsp_ch.cell_value), 0);
        end else begin
          want = grid_results.pop_front();
          if (rsp_ch.status !== want.status) begin
            report_mismatch("status", int'(rsp_ch.status), int'(want.status));
          end
          if (rsp_ch.cell_value !== want.cell_value) begin
            report_mismatch("cell_value", int'(rsp_ch.cell_value), int'(want.cell_value));
          end
          if (rsp_ch.cells_touched !== want.cells_touched) begin
            report_mismatch("cells_touched", int'(rsp_ch.cells_touched),
                            int'(want.cells_touched));
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: the run ends as a failure once no item has moved on either
  // channel for too long.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] no item moved in %0d cycles", $time, stall_cycles);
      $display("occupancy_grid_ray_update: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    grid_result_t missing;

    // The APB inputs are known from time zero on; the channel signals are
    // set by the driver and the monitor while reset is high.
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;

    // Register values after reset.
    grid_cfg.grid_width    = DIM_REG_W'(256);
    grid_cfg.grid_height   = DIM_REG_W'(256);
    grid_cfg.occupied_step = STEP_W'(218);
    grid_cfg.free_step     = STEP_W'(102);
    grid_cfg.floor_value   = FLOOR_W'(-1024);
    grid_cfg.ceiling_value = CEIL_W'(1024);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed items on the reset setting. They wait out the clearing pass,
    // then cover a read of a cleared cell, a ray whose start is its end,
    // the longest diagonal, a shallow line with x falling and y rising, a steep
    // line with x rising and y falling, a horizontal line, rays with a cell off
    // the grid on each side, reads with an end off the grid, a read whose start
    // coordinates are garbage, and repeated hits that reach the ceiling.
    queue_item(KIND_READ, 0, 0, 0, 0);
    queue_item(KIND_RAY, 0, 0, 0, 0);
    queue_item(KIND_RAY, 0, 0, 255, 255);
    queue_item(KIND_RAY, 255, 0, 0, 7);
    queue_item(KIND_RAY, 3, 250, 9, 0);
    queue_item(KIND_RAY, 255, 255, 0, 255);
    queue_item(KIND_RAY, -1, 0, 5, 5);
    queue_item(KIND_RAY, 0, 0, 256, 3);
    queue_item(KIND_RAY, -1024, -1024, 1023, 1023);
    queue_item(KIND_RAY, 5, 5, 5, -1);
    queue_item(KIND_RAY, 10, 255, 10, 256);
    queue_item(KIND_READ, 0, 0, 1023, 0);
    queue_item(KIND_READ, 0, 0, 0, -1024);
    queue_item(KIND_READ, -1024, 1023, 255, 255);
    queue_item(KIND_READ, 0, 0, 128, 128);
    queue_item(KIND_READ, 0, 0, 0, 255);
    repeat (6) queue_item(KIND_RAY, 40, 40, 40, 40);
    repeat (3) queue_item(KIND_RAY, 60, 60, 40, 40);
    queue_item(KIND_READ, 0, 0, 50, 50);
    wait_until_idle();

    // Random phases. Small grids make rays revisit cells, so the clamps get
    // exercised; the size registers go from zero to above the grid limit,
    // the steps and bounds reach their extremes, and one phase puts the
    // floor above the ceiling.
    run_phase(256, 256, 218, 102, -1024, 1024, 0, 0, 150);
    run_phase(16, 16, 218, 102, -1024, 1024, 54, 0, 220);
    run_phase(8, 8, 2047, 2047, -2048, 2047, 0, 54, 180);
    run_phase(1, 1, 0, 0, 0, 0, 10, 10, 60);
    run_phase(0, 256, 300, 300, -500, 500, 0, 0, 40);
    run_phase(511, 300, 500, 37, 700, 100, 54, 0, 150);
    run_phase(32, 5, 1, 2047, -2048, 2047, 0, 54, 200);
    run_phase(256, 1, 218, 102, -1024, 1024, 10, 10, 100);
    run_phase(12, 40, 2047, 1, -1, 0, 0, 0, 150);
    run_phase(24, 24, 218, 102, -1024, 1024, 10, 10, 150);

    repeat (TAIL_CYCLES) @(posedge clk);
    while (grid_results.size() != 0) begin
      missing = grid_results.pop_front();
      report_mismatch("result never arrived", 0, int'(missing.cell_value));
    end
    if (mismatches == 0) begin
      $display("occupancy_grid_ray_update: match");
    end else begin
      $display("occupancy_grid_ray_update: mismatch");
    end
    $finish;
  end

endmodule
